FILE: sv/nsrc_pkg.sv
// Shared types, constants and helpers of the nearest segment row classifier.
// No dependencies; compiled first.
`default_nettype none

package nsrc_pkg;

  // Defaults and fixed formats
  localparam int MAX_ROWS_DEF = 16;
  localparam int FRAC_BITS    = 16;
  localparam int CFG_W        = 30;
  localparam int DIV_STEPS    = 63;

  // Squared-distance saturation and zero-length threshold (2^-2F units)
  localparam logic [63:0] DIST_SAT     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ZERO_LEN_RAW = (64'd1 << (2 * FRAC_BITS)) / 64'd10000000000;

  // Configuration register indexes
  localparam logic [1:0] CFG_BOX_TOL   = 2'd0;
  localparam logic [1:0] CFG_NEAR_LIM  = 2'd1;
  localparam logic [1:0] CFG_ROW_COUNT = 2'd2;

  // Request actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Match kinds
  localparam logic [1:0] KIND_BOX  = 2'd0;
  localparam logic [1:0] KIND_BOX2 = 2'd1;
  localparam logic [1:0] KIND_NEAR = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Candidate distance sources
  localparam logic [1:0] CAND_DA  = 2'd0;
  localparam logic [1:0] CAND_DB  = 2'd1;
  localparam logic [1:0] CAND_SAT = 2'd2;
  localparam logic [1:0] CAND_Q   = 2'd3;

  // Multiplier schedule of the nearest pass
  localparam logic [3:0] ST_ABX2  = 4'd0;
  localparam logic [3:0] ST_ABY2  = 4'd1;
  localparam logic [3:0] ST_DOT_X = 4'd2;
  localparam logic [3:0] ST_DOT_Y = 4'd3;
  localparam logic [3:0] ST_AP_X2 = 4'd4;
  localparam logic [3:0] ST_AP_Y2 = 4'd5;
  localparam logic [3:0] ST_BP_X2 = 4'd6;
  localparam logic [3:0] ST_BP_Y2 = 4'd7;
  localparam logic [3:0] ST_CR_A  = 4'd8;
  localparam logic [3:0] ST_CR_B  = 4'd9;
  localparam logic [3:0] ST_GAP   = 4'd10;
  localparam logic [3:0] ST_HH    = 4'd11;
  localparam logic [3:0] ST_HL    = 4'd12;
  localparam logic [3:0] ST_LL    = 4'd13;
  localparam logic [3:0] ST_FLUSH = 4'd14;

  typedef struct packed {
    logic               action;
    logic [3:0]         entry_index;
    logic [15:0]        entry_row_id;
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } req_word_t;

  typedef struct packed {
    logic        found;
    logic [15:0] matched_row_id;
    logic [1:0]  match_kind;
  } rsp_word_t;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
  } row_t;

  // Controller to datapath
  typedef struct packed {
    logic       wr;
    logic       latch;
    logic       rd;
    logic       wide_tol;
    logic       diff;
    logic       mul_en;
    logic [3:0] step;
    logic       cand_ld;
    logic [1:0] cand_sel;
    logic       div_init;
    logic       div_step;
    logic       pick;
    logic       res_box;
    logic       res_near;
    logic       out_ld;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       box_hit;
    logic       zero_len;
    logic       dot_le0;
    logic       dot_ge;
    logic       div_ovf;
    logic [4:0] row_count;
  } status_t;

  // Saturate a nonnegative wide sum to a 63-bit squared distance
  function automatic logic [63:0] sat64(input logic [69:0] v);
    if (v[69:63] != 7'd0) return DIST_SAT;
    return {1'b0, v[62:0]};
  endfunction

endpackage

`default_nettype wire

FILE: sv/nsrc_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; payload types come from nsrc_pkg at instantiation.
`default_nettype none

interface nsrc_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/nearest_segment_row_classifier_top.sv
// Top level of the nearest segment row classifier.
// Depends on nsrc_pkg, nsrc_stream_if, nsrc_ctrl and nsrc_datapath.
//
// Usage:
//  req carries one word per item. action 0 writes a table row at entry_index
//  (slots at or above MAX_ROWS are ignored) and returns nothing; action 1
//  classifies point_x/point_y and returns one word on rsp.
//  cfg_we/cfg_index/cfg_data write box_tolerance (0), nearest_limit (1) and
//  row_count (2); other indexes are ignored. Write config only while idle.
// Sequence:
//  A query runs the two box passes, each row a table read then a compare,
//  and then the nearest pass: per row a table read, the differences, the
//  shared-multiplier schedule, a decision and, when needed, the restoring
//  divider (one quotient bit a cycle). A box hit in either pass ends the
//  query there, and the nearest pass is skipped.
// Reset: synchronous rst restores register defaults (1.0 m, 5.0 m, 0 rows)
//  and clears handshake state; table contents are undefined until written.
// Stall: the result sits in an output register; the next request is taken
//  while it waits, and a finished query holds until the register frees.
`default_nettype none

module nearest_segment_row_classifier_top
  import nsrc_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  nsrc_stream_if.sink      req,
  nsrc_stream_if.source    rsp,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  cmd_t          cmd;
  status_t       status;
  logic [AW-1:0] row_addr;
  req_word_t     req_word;
  rsp_word_t     rsp_word;

  assign req_word = req.data;
  assign rsp.data = rsp_word;

  nsrc_ctrl #(.MAX_ROWS(MAX_ROWS), .AW(AW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req_word.action),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (status),
    .cmd        (cmd),
    .row_addr   (row_addr)
  );

  nsrc_datapath #(.MAX_ROWS(MAX_ROWS), .AW(AW)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .req_data   (req_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .row_addr   (row_addr),
    .status     (status),
    .rsp_data   (rsp_word)
  );

endmodule

`default_nettype wire

FILE: sv/nsrc_datapath.sv
// Datapath: row table, config registers, box test, shared multiplier,
// accumulators, restoring divider and result registers. Uses nsrc_pkg.
`default_nettype none

module nsrc_datapath
  import nsrc_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int AW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  req_word_t          req_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  cmd_t               cmd,
  input  logic [AW-1:0]      row_addr,
  output status_t            status,
  output rsp_word_t          rsp_data
);

  // Row table
  row_t mem [MAX_ROWS];
  row_t row_q;

  // Config and query registers
  logic [29:0]        box_tol;
  logic [29:0]        near_lim;
  logic [4:0]         row_count;
  logic [59:0]        lim2;
  logic signed [31:0] px;
  logic signed [31:0] py;

  // Differences
  logic signed [32:0] dapx, dapy, dabx, daby, dbpx, dbpy;

  // Multiplier and accumulators
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic               prod_vld;
  logic [3:0]         prod_step;
  logic signed [69:0] p70, acc, acc_sum, acc_dif, acc_neg, dot;
  logic [66:0]        len2;
  logic [63:0]        da, db;
  logic [65:0]        cmag;
  logic [131:0]       c2;

  // Divider
  logic [131:0] rem, dv;
  logic [62:0]  quo;

  // Selection
  logic [63:0] cand, best;
  logic [15:0] best_id;
  logic        have;
  rsp_word_t   res;

  // Box test
  logic [30:0]        tol_eff;
  logic signed [33:0] tol34, px34, py34, lo_x, hi_x, lo_y, hi_y;
  logic signed [33:0] ax34, ay34, bx34, by34;

  // Table write and row read
  always_ff @(posedge clk) begin
    if (cmd.wr && (int'(req_data.entry_index) < MAX_ROWS)) begin
      mem[AW'(req_data.entry_index)] <= '{id: req_data.entry_row_id,
                                          ax: req_data.seg_start_x,
                                          ay: req_data.seg_start_y,
                                          bx: req_data.seg_end_x,
                                          by: req_data.seg_end_y};
    end
    if (cmd.rd) begin
      row_q <= mem[row_addr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box_tol   <= 30'd65536;
      near_lim  <= 30'd327680;
      row_count <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_TOL:   box_tol   <= cfg_data;
        CFG_NEAR_LIM:  near_lim  <= cfg_data;
        CFG_ROW_COUNT: row_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Squared limit; the user must keep config stable while a query runs, the block does not enforce it
  always_ff @(posedge clk) begin
    lim2 <= near_lim * near_lim;
  end

  // Box test on the row just read
  assign tol_eff = cmd.wide_tol ? {box_tol, 1'b0} : {1'b0, box_tol};
  assign tol34   = {3'b000, tol_eff};
  assign px34    = {{2{px[31]}}, px};
  assign py34    = {{2{py[31]}}, py};
  assign ax34    = {{2{row_q.ax[31]}}, row_q.ax};
  assign ay34    = {{2{row_q.ay[31]}}, row_q.ay};
  assign bx34    = {{2{row_q.bx[31]}}, row_q.bx};
  assign by34    = {{2{row_q.by[31]}}, row_q.by};
  assign lo_x    = ((ax34 < bx34) ? ax34 : bx34) - tol34;
  assign hi_x    = ((ax34 > bx34) ? ax34 : bx34) + tol34;
  assign lo_y    = ((ay34 < by34) ? ay34 : by34) - tol34;
  assign hi_y    = ((ay34 > by34) ? ay34 : by34) + tol34;

  // Query point and segment differences
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      px <= req_data.point_x;
      py <= req_data.point_y;
    end
    if (cmd.diff) begin
      dapx <= {px[31], px} - {row_q.ax[31], row_q.ax};
      dapy <= {py[31], py} - {row_q.ay[31], row_q.ay};
      dabx <= {row_q.bx[31], row_q.bx} - {row_q.ax[31], row_q.ax};
      daby <= {row_q.by[31], row_q.by} - {row_q.ay[31], row_q.ay};
      dbpx <= {px[31], px} - {row_q.bx[31], row_q.bx};
      dbpy <= {py[31], py} - {row_q.by[31], row_q.by};
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      ST_ABX2:  begin mul_a = {dabx[32], dabx}; mul_b = {dabx[32], dabx}; end
      ST_ABY2:  begin mul_a = {daby[32], daby}; mul_b = {daby[32], daby}; end
      ST_DOT_X: begin mul_a = {dapx[32], dapx}; mul_b = {dabx[32], dabx}; end
      ST_DOT_Y: begin mul_a = {dapy[32], dapy}; mul_b = {daby[32], daby}; end
      ST_AP_X2: begin mul_a = {dapx[32], dapx}; mul_b = {dapx[32], dapx}; end
      ST_AP_Y2: begin mul_a = {dapy[32], dapy}; mul_b = {dapy[32], dapy}; end
      ST_BP_X2: begin mul_a = {dbpx[32], dbpx}; mul_b = {dbpx[32], dbpx}; end
      ST_BP_Y2: begin mul_a = {dbpy[32], dbpy}; mul_b = {dbpy[32], dbpy}; end
      ST_CR_A:  begin mul_a = {dapx[32], dapx}; mul_b = {daby[32], daby}; end
      ST_CR_B:  begin mul_a = {dapy[32], dapy}; mul_b = {dabx[32], dabx}; end
      ST_HH:    begin mul_a = {1'b0, cmag[65:33]}; mul_b = {1'b0, cmag[65:33]}; end
      ST_HL:    begin mul_a = {1'b0, cmag[65:33]}; mul_b = {1'b0, cmag[32:0]}; end
      ST_LL:    begin mul_a = {1'b0, cmag[32:0]}; mul_b = {1'b0, cmag[32:0]}; end
      default: ;
    endcase
  end

  // Product register
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_en;
    end
    prod      <= mul_a * mul_b;
    prod_step <= cmd.step;
  end

  assign p70     = {{2{prod[67]}}, prod};
  assign acc_sum = acc + p70;
  assign acc_dif = acc - p70;
  assign acc_neg = -acc_dif;

  // Accumulate the tagged product
  always_ff @(posedge clk) begin
    if (prod_vld) begin
      case (prod_step)
        ST_ABX2, ST_DOT_X, ST_AP_X2, ST_BP_X2, ST_CR_A: acc <= p70;
        ST_ABY2:  len2 <= acc_sum[66:0];
        ST_DOT_Y: dot  <= acc_sum;
        ST_AP_Y2: da   <= sat64(acc_sum);
        ST_BP_Y2: db   <= sat64(acc_sum);
        ST_CR_B:  cmag <= acc_dif[69] ? acc_neg[65:0] : acc_dif[65:0];
        ST_HH:    c2   <= {prod[65:0], 66'd0};
        ST_HL:    c2   <= c2 + ({65'd0, prod[66:0]} << 34);
        ST_LL:    c2   <= c2 + {64'd0, prod};
        default: ;
      endcase
    end
  end

  // Restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= c2;
      dv  <= {3'b000, len2, 62'd0};
      quo <= '0;
    end else if (cmd.div_step) begin
      if (rem >= dv) begin
        rem <= rem - dv;
        quo <= {quo[61:0], 1'b1};
      end else begin
        quo <= {quo[61:0], 1'b0};
      end
      dv <= dv >> 1;
    end
  end

  // Candidate load and running minimum
  always_ff @(posedge clk) begin
    if (cmd.cand_ld) begin
      case (cmd.cand_sel)
        CAND_DA:  cand <= da;
        CAND_DB:  cand <= db;
        CAND_SAT: cand <= DIST_SAT;
        CAND_Q:   cand <= {1'b0, quo};
        default:  cand <= DIST_SAT;
      endcase
    end
    if (cmd.pick && (!have || cand < best)) begin
      best    <= cand;
      best_id <= row_q.id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.latch) begin
      have <= 1'b0;
    end else if (cmd.pick) begin
      have <= 1'b1;
    end
  end

  // Result and output word
  always_ff @(posedge clk) begin
    if (cmd.res_box) begin
      res.found          <= 1'b1;
      res.matched_row_id <= row_q.id;
      res.match_kind     <= cmd.wide_tol ? KIND_BOX2 : KIND_BOX;
    end else if (cmd.res_near) begin
      if (have && (best < {4'd0, lim2})) begin
        res.found          <= 1'b1;
        res.matched_row_id <= best_id;
        res.match_kind     <= KIND_NEAR;
      end else begin
        res.found          <= 1'b0;
        res.matched_row_id <= 16'd0;
        res.match_kind     <= KIND_NONE;
      end
    end
    if (cmd.out_ld) begin
      rsp_data <= res;
    end
  end

  // Status to controller
  assign status.box_hit   = (px34 >= lo_x) && (px34 <= hi_x) &&
                            (py34 >= lo_y) && (py34 <= hi_y);
  assign status.zero_len  = (len2 <= {3'b000, ZERO_LEN_RAW});
  assign status.dot_le0   = dot[69] || (dot == 70'sd0);
  assign status.dot_ge    = (dot[68:0] >= {2'b00, len2});
  assign status.div_ovf   = (c2 >= {2'b00, len2, 63'd0});
  assign status.row_count = row_count;

endmodule

`default_nettype wire

FILE: sv/nsrc_ctrl.sv
// Controller: sequences writes, the two box passes, the nearest pass with
// its multiply schedule and divider, and the output handshake. Uses nsrc_pkg.
`default_nettype none

module nsrc_ctrl
  import nsrc_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int AW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_action,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  status_t       status,
  output cmd_t          cmd,
  output logic [AW-1:0] row_addr
);

  localparam int RW = $clog2(MAX_ROWS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BRD   = 4'd1;
  localparam logic [3:0] S_BCHK  = 4'd2;
  localparam logic [3:0] S_NRD   = 4'd3;
  localparam logic [3:0] S_NDIFF = 4'd4;
  localparam logic [3:0] S_NMUL  = 4'd5;
  localparam logic [3:0] S_NDEC  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_DIVQ  = 4'd8;
  localparam logic [3:0] S_NPICK = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]    state, state_next;
  logic [RW-1:0] row, row_next, n;
  logic          pass, pass_next;
  logic [3:0]    step, step_next;
  logic [5:0]    dcnt, dcnt_next;
  logic          out_valid, out_valid_next;
  logic          last;

  // Rows in use, clamped to the table depth
  assign n    = (int'(status.row_count) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(status.row_count);
  assign last = (row == n - RW'(1));

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_valid;
  assign row_addr  = AW'(row);

  // Next state and commands
  always_comb begin
    state_next = state;
    row_next   = row;
    pass_next  = pass;
    step_next  = step;
    dcnt_next  = dcnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_action == ACT_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.latch  = 1'b1;
            row_next   = '0;
            pass_next  = 1'b0;
            state_next = (n == '0) ? S_FIN : S_BRD;
          end
        end
      end
      S_BRD: begin
        cmd.rd     = 1'b1;
        state_next = S_BCHK;
      end
      S_BCHK: begin
        cmd.wide_tol = pass;
        if (status.box_hit) begin
          cmd.res_box = 1'b1;
          state_next  = S_DONE;
        end else if (last) begin
          row_next = '0;
          if (!pass) begin
            pass_next  = 1'b1;
            state_next = S_BRD;
          end else begin
            state_next = S_NRD;
          end
        end else begin
          row_next   = row + RW'(1);
          state_next = S_BRD;
        end
      end
      S_NRD: begin
        cmd.rd     = 1'b1;
        state_next = S_NDIFF;
      end
      S_NDIFF: begin
        cmd.diff   = 1'b1;
        step_next  = ST_ABX2;
        state_next = S_NMUL;
      end
      // Multiply schedule; a gap lets the cross magnitude settle
      S_NMUL: begin
        cmd.step   = step;
        cmd.mul_en = (step != ST_GAP) && (step != ST_FLUSH);
        if (step == ST_FLUSH) begin
          state_next = S_NDEC;
        end else begin
          step_next = step + 4'd1;
        end
      end
      // Pick the distance form: endpoint, saturated or divided
      S_NDEC: begin
        if (status.zero_len || status.dot_le0) begin
          cmd.cand_ld  = 1'b1;
          cmd.cand_sel = CAND_DA;
          state_next   = S_NPICK;
        end else if (status.dot_ge) begin
          cmd.cand_ld  = 1'b1;
          cmd.cand_sel = CAND_DB;
          state_next   = S_NPICK;
        end else if (status.div_ovf) begin
          cmd.cand_ld  = 1'b1;
          cmd.cand_sel = CAND_SAT;
          state_next   = S_NPICK;
        end else begin
          cmd.div_init = 1'b1;
          dcnt_next    = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (dcnt == 6'(DIV_STEPS - 1)) begin
          state_next = S_DIVQ;
        end else begin
          dcnt_next = dcnt + 6'd1;
        end
      end
      S_DIVQ: begin
        cmd.cand_ld  = 1'b1;
        cmd.cand_sel = CAND_Q;
        state_next   = S_NPICK;
      end
      S_NPICK: begin
        cmd.pick = 1'b1;
        if (last) begin
          state_next = S_FIN;
        end else begin
          row_next   = row + RW'(1);
          state_next = S_NRD;
        end
      end
      S_FIN: begin
        cmd.res_near = 1'b1;
        state_next   = S_DONE;
      end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid || rsp_ready) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = cmd.out_ld || (out_valid && !rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row       <= '0;
      pass      <= 1'b0;
      step      <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      pass      <= pass_next;
      step      <= step_next;
      dcnt      <= dcnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Row index stays inside the rows in use while scanning
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_BCHK || state == S_NPICK) |-> (row < n))
    else $error("row index beyond rows in use");

  // A table write returns no result and keeps the block idle
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid && req_action == ACT_WRITE) |=>
      (state == S_IDLE && !cmd.out_ld))
    else $error("table write left idle");

  // Loading the output register always raises valid
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |=> out_valid)
    else $error("output word lost");

  // Divider never runs past its quotient width
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dcnt <= 6'(DIV_STEPS - 1)))
    else $error("divider overran");

endmodule

`default_nettype wire

FILE: sim/nearest_segment_row_classifier_top_tb.sv
// Testbench for nearest_segment_row_classifier_top: drives row writes and point
// queries, predicts each classification and checks the responses in order.
// Depends on nsrc_pkg, nsrc_stream_if and the classifier RTL.
`timescale 1ns / 100ps

module nearest_segment_row_classifier_top_tb;
  import nsrc_pkg::*;

  localparam int  ROWS       = 16;
  localparam int  RANDOM_N   = 270;
  localparam int  SETTLE     = 30;
  localparam longint LIMIT   = 10_000_000;
  localparam int  M          = 65536;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_BOX_TOL;
  logic [CFG_W-1:0] cfg_data = '0;

  nsrc_stream_if #(.word_t(req_word_t)) req_if ();
  nsrc_stream_if #(.word_t(rsp_word_t)) rsp_if ();

  nearest_segment_row_classifier_top dut (
    .clk(clk), .rst(rst), .req(req_if), .rsp(rsp_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: segment table and register copies
  logic [15:0]        tbl_id [ROWS];
  logic signed [31:0] tbl_ax [ROWS];
  logic signed [31:0] tbl_ay [ROWS];
  logic signed [31:0] tbl_bx [ROWS];
  logic signed [31:0] tbl_by [ROWS];
  logic [CFG_W-1:0]   tol_q, lim_q;
  logic [4:0]         rows_q;

  req_word_t pending_words[$];
  rsp_word_t expected_results[$];
  int     errors = 0;
  longint cyc = 0;
  int     accepted = 0;
  logic   req_took = 1'b0;
  int     hold_left = 0;
  logic   hold_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] sat_sq(logic [135:0] v);
    if (v >= 136'h8000_0000_0000_0000) return DIST_SAT;
    return v[63:0];
  endfunction

  // Exact squared point-to-segment distance, t clamped to the segment
  function automatic logic [63:0] seg_sq(int i, logic signed [31:0] px,
                                         logic signed [31:0] py);
    logic signed [135:0] ax, ay, bx, by, apx, apy, abx, aby, len2, dt, cr;
    logic [135:0] c2;
    ax = tbl_ax[i]; ay = tbl_ay[i]; bx = tbl_bx[i]; by = tbl_by[i];
    apx = px - ax; apy = py - ay;
    abx = bx - ax; aby = by - ay;
    len2 = abx * abx + aby * aby;
    if (len2 <= $signed({72'd0, ZERO_LEN_RAW})) return sat_sq(apx * apx + apy * apy);
    dt = apx * abx + apy * aby;
    if (dt <= 0) return sat_sq(apx * apx + apy * apy);
    if (dt >= len2) return sat_sq((px - bx) * (px - bx) + (py - by) * (py - by));
    cr = apx * aby - apy * abx;
    c2 = cr * cr;
    return sat_sq(c2 / $unsigned(len2));
  endfunction

  function automatic logic box_hit(int i, longint px, longint py, longint t);
    longint ax, ay, bx, by;
    ax = tbl_ax[i]; ay = tbl_ay[i]; bx = tbl_bx[i]; by = tbl_by[i];
    return px >= ((ax < bx ? ax : bx) - t) && px <= ((ax > bx ? ax : bx) + t) &&
           py >= ((ay < by ? ay : by) - t) && py <= ((ay > by ? ay : by) + t);
  endfunction

  function automatic rsp_word_t classify(logic signed [31:0] px, logic signed [31:0] py);
    rsp_word_t r;
    int n, best_i;
    logic [63:0] d, best_d;
    longint t;
    n = (rows_q > ROWS) ? ROWS : rows_q;
    t = longint'(tol_q);
    r = '{found: 1'b0, matched_row_id: 16'd0, match_kind: KIND_NONE};
    for (int pass = 0; pass < 2; pass++)
      for (int i = 0; i < n; i++)
        if (box_hit(i, px, py, pass ? 2 * t : t))
          return '{found: 1'b1, matched_row_id: tbl_id[i],
                   match_kind: pass ? KIND_BOX2 : KIND_BOX};
    best_i = -1;
    best_d = '0;
    for (int i = 0; i < n; i++) begin
      d = seg_sq(i, px, py);
      if (best_i < 0 || d < best_d) begin
        best_i = i;
        best_d = d;
      end
    end
    if (best_i >= 0 && {64'd0, best_d} < {68'd0, lim_q} * {68'd0, lim_q})
      r = '{found: 1'b1, matched_row_id: tbl_id[best_i], match_kind: KIND_NEAR};
    return r;
  endfunction

  task automatic report(string what, rsp_word_t got, rsp_word_t want);
    errors++;
    $display("mismatch %s: got %0d/%h/%0d want %0d/%h/%0d at cycle %0d", what,
             got.found, got.matched_row_id, got.match_kind,
             want.found, want.matched_row_id, want.match_kind, cyc);
  endtask

  function automatic logic calm();
    return (cyc % 20000) < 3000;
  endfunction

  // Monitor: predict accepted requests, check responses
  always @(posedge clk) begin
    rsp_word_t want;
    cyc <= cyc + 1;
    req_took <= req_if.valid && req_if.ready;
    if (!rst && req_if.valid && req_if.ready) begin
      accepted <= accepted + 1;
      if (req_if.data.action == ACT_WRITE) begin
        tbl_id[req_if.data.entry_index] <= req_if.data.entry_row_id;
        tbl_ax[req_if.data.entry_index] <= req_if.data.seg_start_x;
        tbl_ay[req_if.data.entry_index] <= req_if.data.seg_start_y;
        tbl_bx[req_if.data.entry_index] <= req_if.data.seg_end_x;
        tbl_by[req_if.data.entry_index] <= req_if.data.seg_end_y;
      end else
        expected_results.insert(expected_results.size(),
                                classify(req_if.data.point_x, req_if.data.point_y));
    end
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0)
        report("unexpected word", rsp_if.data, '0);
      else begin
        want = expected_results.pop_front();
        if (rsp_if.data.found != want.found) report("found", rsp_if.data, want);
        else if (rsp_if.data.matched_row_id != want.matched_row_id)
          report("row id", rsp_if.data, want);
        else if (rsp_if.data.match_kind != want.match_kind)
          report("kind", rsp_if.data, want);
      end
    end
    if (cyc > LIMIT) begin
      $display("timeout at cycle %0d", cyc);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Request driver
  always @(negedge clk) begin
    if (rst) req_if.valid <= 1'b0;
    else if (!req_if.valid || req_took) begin
      if (pending_words.size() != 0 && (calm() || $urandom_range(99) >= 33)) begin
        req_if.data  <= pending_words.pop_front();
        req_if.valid <= 1'b1;
      end else
        req_if.valid <= 1'b0;
    end
  end

  // Response sink, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) rsp_if.ready <= 1'b0;
    else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (!hold_done && accepted > 400) begin
      hold_done <= 1'b1;
      hold_left <= 600;
      rsp_if.ready <= 1'b0;
    end else
      rsp_if.ready <= calm() || $urandom_range(99) >= 33;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
  end

  task automatic set_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_BOX_TOL:   tol_q = v;
      CFG_NEAR_LIM:  lim_q = v;
      CFG_ROW_COUNT: rows_q = v[4:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [CFG_W-1:0] t, logic [CFG_W-1:0] l, logic [4:0] n);
    set_reg(CFG_BOX_TOL, t);
    set_reg(CFG_NEAR_LIM, l);
    set_reg(CFG_ROW_COUNT, {25'd0, n});
    set_reg(2'd3, '1);   // unused index, ignored
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() != 0 || req_if.valid || expected_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_row(int slot, int id, int ax, int ay, int bx, int by);
    req_word_t w;
    w = '0;
    w.action = ACT_WRITE; w.entry_index = 4'(slot); w.entry_row_id = 16'(id);
    w.seg_start_x = ax; w.seg_start_y = ay; w.seg_end_x = bx; w.seg_end_y = by;
    w.point_x = $urandom; w.point_y = $urandom;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic put_query(int px, int py);
    req_word_t w;
    w = '0;
    w.action = ACT_QUERY;
    w.entry_index = 4'($urandom); w.entry_row_id = 16'($urandom);
    w.seg_start_x = $urandom; w.seg_start_y = $urandom;
    w.seg_end_x = $urandom; w.seg_end_y = $urandom;
    w.point_x = px; w.point_y = py;
    pending_words.insert(pending_words.size(), w);
  endtask

  function automatic int coord();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(4_000_000) - 2_000_000;
  endfunction

  task automatic random_items(int count);
    int ax, ay;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 35) begin
        ax = coord(); ay = coord();
        case ($urandom_range(9))
          0: put_row($urandom_range(15), $urandom, ax, ay, ax, ay);
          1, 2, 3: put_row($urandom_range(15), $urandom, ax, ay,
                           ax + $urandom_range(1_000_000) - 500_000,
                           ay + $urandom_range(1_000_000) - 500_000);
          default: put_row($urandom_range(15), $urandom, ax, ay, coord(), coord());
        endcase
      end else
        put_query(coord(), coord());
    end
  endtask

  initial begin
    tol_q = 30'd65536; lim_q = 30'd327680; rows_q = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: a known table, then one query per match path
    configure(30'd65536, 30'd327680, 5'd15);
    put_row(0, 16'h0001, 0, 0, 10 * M, 0);
    put_row(1, 16'hFFFF, -50 * M, -50 * M, -50 * M, -50 * M);   // zero-length
    put_row(2, 16'h0002, 50 * M, 50 * M, 60 * M, 50 * M);       // tie pair
    put_row(3, 16'h0003, 50 * M, 50 * M, 60 * M, 50 * M);
    for (int s = 4; s < 15; s++)
      put_row(s, 16'h0000 + s, 20000 * M + s, -20000 * M, 21000 * M, -21000 * M);
    put_row(15, 16'h0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    put_query(5 * M, M / 2);            // inside box
    put_query(5 * M, 3 * M / 2);        // inside doubled box
    put_query(5 * M, 4 * M);            // nearest, interior of segment
    put_query(-4 * M, 0);               // nearest, clamped at start
    put_query(14 * M, 0);               // nearest, clamped at end
    put_query(-50 * M, -53 * M);        // zero-length segment
    put_query(55 * M, 54 * M);          // tie picks the lower row
    put_query(5 * M, 100 * M);          // no match
    put_query(32'h7FFF_FFFF, 32'h8000_0000);
    wait_idle();
    configure(30'd65536, 30'd327680, 5'd16);
    put_query(5 * M, 100 * M);          // now caught by the full-range row
    put_query(32'h8000_0000, 32'h7FFF_FFFF);
    wait_idle();

    // Random phases over register settings, extremes included
    configure(30'd65536, 30'd327680, 5'd16);
    random_items(RANDOM_N);
    wait_idle();
    configure(30'd0, 30'd0, 5'd1);
    random_items(RANDOM_N);
    wait_idle();
    configure(30'h3FFF_FFFF, 30'h3FFF_FFFF, 5'd16);
    random_items(RANDOM_N);
    wait_idle();
    configure(30'd0, 30'h3FFF_FFFF, 5'd31);   // above the table size
    random_items(RANDOM_N);
    wait_idle();
    configure(30'd0, 30'd0, 5'd0);
    random_items(RANDOM_N / 2);
    wait_idle();
    configure(CFG_W'($urandom_range(200_000)), CFG_W'($urandom_range(3_000_000)),
              5'($urandom_range(16)));
    random_items(RANDOM_N);
    wait_idle();
    repeat (100) @(posedge clk);

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
